// File: src/imh_pkg.sv
// Shared types and constants for the indexed min-heap.
package imh_pkg;
    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DECREASE = 2'd1;
    localparam logic [1:0] OP_EXTRACT  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL_DUP  = 3'd2;
    localparam logic [2:0] ST_ABSENT    = 3'd3;
    localparam logic [2:0] ST_NOT_LESS  = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  vertex_id;
        logic [31:0] key_in;
        logic [7:0]  payload_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  vertex_out;
        logic [31:0] key_out;
        logic [7:0]  payload_out;
        logic [8:0]  occupancy;
    } t_rsp;

    // One heap slot entry.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [7:0]          vertex;
        logic [7:0]          payload;
    } t_slot;
endpackage

// File: src/imh_if.sv
// Valid/ready channel interfaces for requests and responses.
interface imh_req_if import imh_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with insert, decrease-key and extract-min.
// One word in flight. A rejected or ignored word goes straight to its response;
// insert and decrease-key sift up one level at a time, extract-min sifts down.
// A stalled response holds the block. Reset clears the vertex presence bits and the
// entry count; slot and vertex-to-slot memories hold garbage until written.
module indexed_min_heap_decrease_key import imh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imh_req_if.sink   i_req,
    imh_rsp_if.source o_rsp
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAPRD = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_UPRD  = 4'd3;
    localparam logic [3:0] S_UPCMP = 4'd4;
    localparam logic [3:0] S_EXRD  = 4'd5;
    localparam logic [3:0] S_EXLST = 4'd6;
    localparam logic [3:0] S_DNRDL = 4'd7;
    localparam logic [3:0] S_DNRDR = 4'd8;
    localparam logic [3:0] S_DNCMP = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;
    localparam logic [3:0] S_DNWT  = 4'd11;

    t_slot slot_mem [CAPACITY];
    logic [SLOT_BITS-1:0] map_mem [256];
    logic [255:0] r_present;

    logic [3:0]            r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_req                  r_req, n_req;
    t_slot                 r_cur, n_cur;      // entry being sifted
    logic [SLOT_BITS-1:0]  r_idx, n_idx;      // its current slot
    t_slot                 r_lft, n_lft;
    logic [SLOT_BITS:0]    r_cidx, n_cidx;    // chosen child / parent slot
    t_rsp                  r_rsp, n_rsp;

    // memory ports
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    t_slot                 rd_data;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    t_slot                 wr_data;
    logic                  mw_en;
    logic [7:0]            mw_addr;
    logic [SLOT_BITS-1:0]  mw_data;
    logic [SLOT_BITS-1:0]  map_rd;
    logic                  pr_set, pr_clr;
    logic [7:0]            pr_set_v, pr_clr_v;

    always_ff @(posedge i_clk) begin
        if (rd_en) rd_data <= slot_mem[rd_addr];
        if (wr_en) slot_mem[wr_addr] <= wr_data;
        // address follows the word being accepted, so the slot is ready in S_MAPRD
        map_rd <= map_mem[n_req.vertex_id];
        if (mw_en) map_mem[mw_addr] <= mw_data;
    end

    logic [SLOT_BITS-1:0] last_idx, par_idx;
    logic [SLOT_BITS:0]   lchild, rchild;
    assign last_idx = SLOT_BITS'(r_count - 1'b1);
    assign par_idx  = SLOT_BITS'((r_idx - 1'b1) >> 1);
    assign lchild   = {r_idx, 1'b1};
    assign rchild   = {r_idx, 1'b0} + (SLOT_BITS+1)'(2);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_RESP);
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state; n_count = r_count; n_req = r_req; n_cur = r_cur;
        n_idx = r_idx; n_lft = r_lft; n_cidx = r_cidx; n_rsp = r_rsp;
        rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = r_cur;
        mw_en = 1'b0; mw_addr = r_cur.vertex; mw_data = r_idx;
        pr_set = 1'b0; pr_set_v = r_req.vertex_id; pr_clr = 1'b0; pr_clr_v = rd_data.vertex;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.data;
                    n_rsp = '0;
                    n_rsp.occupancy = 9'(r_count);
                    case (i_req.data.opcode)
                        OP_INSERT: begin
                            if (r_present[i_req.data.vertex_id] ||
                                r_count >= COUNT_BITS'(CAPACITY)) begin
                                n_rsp.status = ST_FULL_DUP; n_state = S_RESP;
                            end else begin
                                n_cur = '{key: KEY_BITS'(i_req.data.key_in),
                                          vertex: i_req.data.vertex_id,
                                          payload: i_req.data.payload_in};
                                n_idx = SLOT_BITS'(r_count);
                                n_count = r_count + 1'b1;
                                n_rsp.occupancy = 9'(r_count + 1'b1);
                                n_state = S_UPRD;
                            end
                        end
                        OP_DECREASE: begin
                            if (!r_present[i_req.data.vertex_id]) begin
                                n_rsp.status = ST_ABSENT; n_state = S_RESP;
                            end else n_state = S_MAPRD;
                        end
                        OP_EXTRACT: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_EMPTY; n_state = S_RESP;
                            end else begin
                                rd_en = 1'b1; rd_addr = '0; n_state = S_EXRD;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_MAPRD: begin
                rd_en = 1'b1; rd_addr = map_rd; n_idx = map_rd; n_state = S_DEC;
            end
            S_DEC: begin
                if (!(KEY_BITS'(r_req.key_in) < rd_data.key)) begin
                    n_rsp.status = ST_NOT_LESS; n_state = S_RESP;
                end else begin
                    n_cur = '{key: KEY_BITS'(r_req.key_in), vertex: rd_data.vertex,
                              payload: r_req.payload_in};
                    n_state = S_UPRD;
                end
            end
            S_UPRD: begin
                // place current entry at its slot, then fetch parent
                wr_en = 1'b1; wr_addr = r_idx; mw_en = 1'b1;
                if (r_idx == '0) n_state = S_RESP;
                else begin
                    rd_en = 1'b1; rd_addr = par_idx; n_cidx = {1'b0, par_idx};
                    n_state = S_UPCMP;
                end
                if (r_req.opcode == OP_INSERT) pr_set = 1'b1;
            end
            S_UPCMP: begin
                if (r_cur.key < rd_data.key) begin
                    wr_en = 1'b1; wr_addr = r_idx; wr_data = rd_data;
                    mw_en = 1'b1; mw_addr = rd_data.vertex;
                    n_idx = SLOT_BITS'(r_cidx);
                    n_state = S_UPRD;
                end else n_state = S_RESP;
            end
            S_EXRD: begin
                n_rsp.vertex_out = rd_data.vertex;
                n_rsp.key_out = 32'(rd_data.key);
                n_rsp.payload_out = rd_data.payload;
                pr_clr = 1'b1;
                n_count = r_count - 1'b1;
                n_rsp.occupancy = 9'(r_count - 1'b1);
                n_idx = '0;
                if (r_count == COUNT_BITS'(1)) n_state = S_RESP;
                else begin
                    rd_en = 1'b1; rd_addr = last_idx; n_state = S_EXLST;
                end
            end
            S_EXLST: begin
                n_cur = rd_data; n_state = S_DNWT;
            end
            S_DNWT: begin
                // write current at r_idx, read children
                wr_en = 1'b1; wr_addr = r_idx; mw_en = 1'b1;
                if (lchild >= (SLOT_BITS+1)'(r_count)) n_state = S_RESP;
                else begin
                    rd_en = 1'b1; rd_addr = SLOT_BITS'(lchild); n_state = S_DNRDL;
                end
            end
            S_DNRDL: begin
                n_lft = rd_data; n_cidx = lchild;
                if (rchild < (SLOT_BITS+1)'(r_count)) begin
                    rd_en = 1'b1; rd_addr = SLOT_BITS'(rchild); n_state = S_DNRDR;
                end else n_state = S_DNCMP;
            end
            S_DNRDR: begin
                if (!(r_lft.key < rd_data.key)) begin
                    n_lft = rd_data; n_cidx = rchild;
                end
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                if (r_cur.key > r_lft.key) begin
                    wr_en = 1'b1; wr_addr = r_idx; wr_data = r_lft;
                    mw_en = 1'b1; mw_addr = r_lft.vertex;
                    n_idx = SLOT_BITS'(r_cidx);
                    n_state = S_DNWT;
                end else n_state = S_RESP;
            end
            S_RESP: if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_present <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count;
            if (pr_set) r_present[pr_set_v] <= 1'b1;
            if (pr_clr) r_present[pr_clr_v] <= 1'b0;
        end
        r_req <= n_req; r_cur <= n_cur; r_idx <= n_idx; r_lft <= n_lft;
        r_cidx <= n_cidx; r_rsp <= n_rsp;
    end
endmodule

// File: src/imh_checker.sv
// Port-level checks for the indexed min-heap, bound to the top level.
module imh_port_checks import imh_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input t_rsp rsp
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req_ready && rsp_valid)) else $error("ready while word pending");
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp.occupancy <= 9'(CAPACITY)) else $error("occupancy range");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.key_out == '0 && rsp.vertex_out == '0)
        else $error("fields nonzero on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");
endmodule

bind indexed_min_heap_decrease_key imh_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready), .rsp(o_rsp.data)
);
